// ----- hdl/blps_pkg.sv -----
// ----------------------------------------------------------------------------
// Bresenham line stepper package
// Shared widths, codes and stage types for the line pixel stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package blps_pkg;

	// Coordinate and datapath widths.
	localparam int COORD_BITS  = 11;
	localparam int ERR_BITS    = COORD_BITS + 3;
	localparam int OFFSET_BITS = 25;
	localparam int WORD_BITS   = 24;
	localparam int PITCH_BITS  = 14;
	localparam int LEVEL_BITS  = 8;
	localparam int FMT_BITS    = 2;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 14;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic signed [ERR_BITS-1:0] err_t;

	// Item kinds.
	localparam logic KIND_START   = 1'b0;
	localparam logic KIND_ADVANCE = 1'b1;

	// Pixel format codes.
	localparam logic [FMT_BITS-1:0] FMT_RGB565 = 2'd0;
	localparam logic [FMT_BITS-1:0] FMT_RGB888 = 2'd1;
	localparam logic [FMT_BITS-1:0] FMT_XRGB   = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] REG_PIXEL_FORMAT = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ROW_PITCH    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_RED_LEVEL    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_GREEN_LEVEL  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_BLUE_LEVEL   = 3'd4;

	// Reset values of the configuration registers.
	localparam logic [FMT_BITS-1:0]   FMT_RESET   = FMT_XRGB;
	localparam logic [PITCH_BITS-1:0] PITCH_RESET = 14'd7680;
	localparam logic [LEVEL_BITS-1:0] RED_RESET   = 8'd0;
	localparam logic [LEVEL_BITS-1:0] GREEN_RESET = 8'd255;
	localparam logic [LEVEL_BITS-1:0] BLUE_RESET  = 8'd0;

	// Configuration as seen by the datapath.
	typedef struct packed {
		logic [FMT_BITS-1:0]   fmt;
		logic [PITCH_BITS-1:0] pitch;
		logic [LEVEL_BITS-1:0] red;
		logic [LEVEL_BITS-1:0] green;
		logic [LEVEL_BITS-1:0] blue;
	} blps_cfg_t;

	// Pixel stage between the stepper and the formatter.
	typedef struct packed {
		logic   vld;
		logic   pix_valid;
		coord_t x;
		coord_t y;
		logic   last;
	} blps_pix_t;

endpackage

`default_nettype wire

// ----- hdl/blps_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// Holds pixel format, row pitch and drawing colour, written over a
// valid/ready beat. Writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module blps_cfg_regs (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [blps_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  wire logic [blps_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	output blps_pkg::blps_cfg_t                        cfg
);
	import blps_pkg::*;

	blps_cfg_t cfg_q;

	// The register file never pushes back.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register writes, each value cut to its register width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fmt   <= FMT_RESET;
			cfg_q.pitch <= PITCH_RESET;
			cfg_q.red   <= RED_RESET;
			cfg_q.green <= GREEN_RESET;
			cfg_q.blue  <= BLUE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PIXEL_FORMAT: cfg_q.fmt   <= cfg_data[FMT_BITS-1:0];
				REG_ROW_PITCH:    cfg_q.pitch <= cfg_data[PITCH_BITS-1:0];
				REG_RED_LEVEL:    cfg_q.red   <= cfg_data[LEVEL_BITS-1:0];
				REG_GREEN_LEVEL:  cfg_q.green <= cfg_data[LEVEL_BITS-1:0];
				REG_BLUE_LEVEL:   cfg_q.blue  <= cfg_data[LEVEL_BITS-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hdl/blps_stepper.sv -----
// ----------------------------------------------------------------------------
// Line stepper
// Holds the Bresenham state, sets up a line on a start beat and takes one
// error step on an advance beat, handing the pixel on in a stage register.
// ----------------------------------------------------------------------------
`default_nettype none

module blps_stepper (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire logic             kind,
	input  wire blps_pkg::coord_t start_x,
	input  wire blps_pkg::coord_t start_y,
	input  wire blps_pkg::coord_t end_x,
	input  wire blps_pkg::coord_t end_y,
	input  wire logic             s1_take,
	output blps_pkg::blps_pix_t   pix_s1
);
	import blps_pkg::*;

	// Line state.
	logic   active_q;
	coord_t pos_x_q;
	coord_t pos_y_q;
	coord_t major_end_q;
	coord_t dmaj_q;
	coord_t dmin_q;
	err_t   err_q;
	logic   neg_q;
	logic   steep_q;

	// Next state.
	logic   active_d;
	coord_t pos_x_d;
	coord_t pos_y_d;
	coord_t major_end_d;
	coord_t dmaj_d;
	coord_t dmin_d;
	err_t   err_d;
	logic   neg_d;
	logic   steep_d;

	blps_pix_t s1_d;
	blps_pix_t s1_q;
	logic      s1_open;
	logic      accept;

	// Setup temporaries.
	coord_t adx;
	coord_t ady;
	logic   swap;
	coord_t sx;
	coord_t sy;
	coord_t ex;
	coord_t ey;

	// The stage takes a beat when it is empty or drains this cycle.
	assign s1_open    = !s1_q.vld || s1_take;
	assign item_stall = !s1_open;
	assign accept     = item_valid && s1_open;
	assign pix_s1     = s1_q;

	// Line setup and error step.
	always_comb begin
		active_d    = active_q;
		pos_x_d     = pos_x_q;
		pos_y_d     = pos_y_q;
		major_end_d = major_end_q;
		dmaj_d      = dmaj_q;
		dmin_d      = dmin_q;
		err_d       = err_q;
		neg_d       = neg_q;
		steep_d     = steep_q;
		adx  = (end_x >= start_x) ? end_x - start_x : start_x - end_x;
		ady  = (end_y >= start_y) ? end_y - start_y : start_y - end_y;
		swap = 1'b0;
		sx   = start_x;
		sy   = start_y;
		ex   = end_x;
		ey   = end_y;
		s1_d = '0;
		s1_d.vld = 1'b1;

		if (kind == KIND_START) begin
			// Pick the major axis and order the endpoints along it.
			steep_d = (ady >= adx);
			swap    = steep_d ? (start_y > end_y) : (start_x > end_x);
			sx = swap ? end_x : start_x;
			sy = swap ? end_y : start_y;
			ex = swap ? start_x : end_x;
			ey = swap ? start_y : end_y;
			pos_x_d = sx;
			pos_y_d = sy;
			if (steep_d) begin
				major_end_d = ey;
				dmaj_d      = ady;
				dmin_d      = adx;
				neg_d       = (ex < sx);
			end else begin
				major_end_d = ex;
				dmaj_d      = adx;
				dmin_d      = ady;
				neg_d       = (ey < sy);
			end
			err_d    = $signed({2'b00, dmin_d, 1'b0}) - $signed({3'b000, dmaj_d});
			active_d = ((steep_d ? sy : sx) != major_end_d);
			s1_d.pix_valid = 1'b1;
			s1_d.x         = pos_x_d;
			s1_d.y         = pos_y_d;
			s1_d.last      = !active_d;
		end else if (active_q) begin
			// Minor step when the error is positive, then the major step.
			if (err_q > 0) begin
				if (steep_q) begin
					pos_x_d = neg_q ? pos_x_q - coord_t'(1) : pos_x_q + coord_t'(1);
				end else begin
					pos_y_d = neg_q ? pos_y_q - coord_t'(1) : pos_y_q + coord_t'(1);
				end
				err_d = err_q - $signed({2'b00, dmaj_q, 1'b0});
			end
			err_d = err_d + $signed({2'b00, dmin_q, 1'b0});
			if (steep_q) begin
				pos_y_d = pos_y_q + coord_t'(1);
			end else begin
				pos_x_d = pos_x_q + coord_t'(1);
			end
			active_d = ((steep_q ? pos_y_d : pos_x_d) != major_end_q);
			s1_d.pix_valid = 1'b1;
			s1_d.x         = pos_x_d;
			s1_d.y         = pos_y_d;
			s1_d.last      = !active_d;
		end
	end

	// State registers, updated on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			major_end_q <= '0;
			dmaj_q      <= '0;
			dmin_q      <= '0;
			err_q       <= '0;
			neg_q       <= 1'b0;
			steep_q     <= 1'b0;
		end else if (accept) begin
			active_q    <= active_d;
			pos_x_q     <= pos_x_d;
			pos_y_q     <= pos_y_d;
			major_end_q <= major_end_d;
			dmaj_q      <= dmaj_d;
			dmin_q      <= dmin_d;
			err_q       <= err_d;
			neg_q       <= neg_d;
			steep_q     <= steep_d;
		end
	end

	// Pixel stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= '0;
		end else if (s1_open) begin
			if (accept) begin
				s1_q <= s1_d;
			end else begin
				s1_q.vld <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	// A pixel waiting on the formatter stays put.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_q.vld && !s1_take |=> $stable(s1_q))
		else $error("stepper stage changed while blocked");

	// The last flag of a pixel matches the line going inactive.
	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (!s1_q.pix_valid || (active_q != s1_q.last)))
		else $error("last flag disagrees with line state");

	// An advance with no line produces an empty pixel.
	a_idle_advance: assert property (@(posedge clk) disable iff (!arst_n)
		accept && kind == KIND_ADVANCE && !active_q |=> !s1_q.pix_valid)
		else $error("pixel emitted with no active line");

	// The error term stays within twice the largest delta.
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q || ((err_q <= $signed({2'b00, dmin_q, 1'b0}))
			&& (err_q >= -$signed({2'b00, dmaj_q, 1'b0}))))
		else $error("error term out of range");
`endif

endmodule

`default_nettype wire

// ----- hdl/blps_formatter.sv -----
// ----------------------------------------------------------------------------
// Pixel formatter
// Turns a stepped pixel into its framebuffer byte offset and packed colour
// word and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module blps_formatter (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire blps_pkg::blps_cfg_t                  cfg,
	input  wire blps_pkg::blps_pix_t                  pix_s1,
	output logic                                      s1_take,
	output logic                                      result_valid,
	input  wire logic                                 result_stall,
	output logic                                      pixel_valid,
	output blps_pkg::coord_t                          pixel_x,
	output blps_pkg::coord_t                          pixel_y,
	output logic [blps_pkg::OFFSET_BITS-1:0]          byte_offset,
	output logic [blps_pkg::WORD_BITS-1:0]            pixel_word,
	output logic                                      last_pixel
);
	import blps_pkg::*;

	logic                                 res_vld_q;
	logic                                 pix_valid_q;
	coord_t                               x_q;
	coord_t                               y_q;
	logic [OFFSET_BITS-1:0]               offset_q;
	logic [WORD_BITS-1:0]                 word_q;
	logic                                 last_q;

	logic [OFFSET_BITS-1:0]               x_ext;
	logic [OFFSET_BITS-1:0]               x_term;
	logic [COORD_BITS+PITCH_BITS-1:0]     y_prod;
	logic [OFFSET_BITS-1:0]               offset_d;
	logic [WORD_BITS-1:0]                 word_d;

	// The output register takes a beat when empty or being drained.
	assign s1_take = !res_vld_q || !result_stall;

	// Byte offset: x scaled by bytes per pixel plus y times row pitch.
	always_comb begin
		x_ext = OFFSET_BITS'(pix_s1.x);
		case (cfg.fmt)
			FMT_RGB565: x_term = x_ext << 1;
			FMT_RGB888: x_term = x_ext + (x_ext << 1);
			default:    x_term = x_ext << 2;
		endcase
		y_prod   = pix_s1.y * cfg.pitch;
		offset_d = x_term + OFFSET_BITS'(y_prod);
	end

	// Colour word for the configured format.
	always_comb begin
		case (cfg.fmt)
			FMT_RGB565: word_d = {8'd0, cfg.red[7:3], cfg.green[7:2], cfg.blue[7:3]};
			default:    word_d = {cfg.red, cfg.green, cfg.blue};
		endcase
	end

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (s1_take) begin
			res_vld_q <= pix_s1.vld;
		end
	end

	// Output payload; an empty pixel reads as all zeros.
	always_ff @(posedge clk) begin
		if (s1_take && pix_s1.vld) begin
			pix_valid_q <= pix_s1.pix_valid;
			x_q         <= pix_s1.x;
			y_q         <= pix_s1.y;
			last_q      <= pix_s1.last;
			offset_q    <= pix_s1.pix_valid ? offset_d : '0;
			word_q      <= pix_s1.pix_valid ? word_d : '0;
		end
	end

	assign result_valid = res_vld_q;
	assign pixel_valid  = pix_valid_q;
	assign pixel_x      = x_q;
	assign pixel_y      = y_q;
	assign byte_offset  = offset_q;
	assign pixel_word   = word_q;
	assign last_pixel   = last_q;

endmodule

`default_nettype wire

// ----- hdl/bresenham_line_pixel_stepper.sv -----
// ----------------------------------------------------------------------------
// Bresenham line pixel stepper
// Pipeline: two register stages; a result moves from the stepper's pixel stage
// register into the formatter's output register, and result_stall can hold both.
// Throughput: one item per cycle while item_stall is low; the Bresenham state
// updates in the same cycle an item is taken, so advances run back to back.
// Reset: arst_n clears the line state and both stage valids at once and
// loads the register defaults (32-bit format, pitch 7680, green colour).
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_line_pixel_stepper (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// Item channel
	input  wire logic                                 item_valid,
	output logic                                      item_stall,
	input  wire logic                                 kind,
	input  wire blps_pkg::coord_t                     start_x,
	input  wire blps_pkg::coord_t                     start_y,
	input  wire blps_pkg::coord_t                     end_x,
	input  wire blps_pkg::coord_t                     end_y,
	// Result channel
	output logic                                      result_valid,
	input  wire logic                                 result_stall,
	output logic                                      pixel_valid,
	output blps_pkg::coord_t                          pixel_x,
	output blps_pkg::coord_t                          pixel_y,
	output logic [blps_pkg::OFFSET_BITS-1:0]          byte_offset,
	output logic [blps_pkg::WORD_BITS-1:0]            pixel_word,
	output logic                                      last_pixel,
	// Configuration channel
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [blps_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  wire logic [blps_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import blps_pkg::*;

	blps_cfg_t cfg;
	blps_pix_t pix_s1;
	logic      s1_take;

	// Configuration registers.
	blps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Bresenham state and first stage.
	blps_stepper u_stepper (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.kind       (kind),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.s1_take    (s1_take),
		.pix_s1     (pix_s1)
	);

	// Address and colour, output register.
	blps_formatter u_formatter (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.pix_s1       (pix_s1),
		.s1_take      (s1_take),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.pixel_valid  (pixel_valid),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.byte_offset  (byte_offset),
		.pixel_word   (pixel_word),
		.last_pixel   (last_pixel)
	);

endmodule

`default_nettype wire
